// ===== rtl/core/bfla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block free list allocator package
// Sizes, field widths, mode and status codes and shared types.
// ----------------------------------------------------------------------------
package bfla_pkg;

    localparam int BLOCK_SLOTS = 1024;
    localparam int RING_AW     = $clog2(BLOCK_SLOTS);
    localparam int CNT_W       = RING_AW + 1;

    localparam int BLK_W   = 10;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int FREE_W  = 11;
    localparam int FRESH_W = 11;

    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REBUILD = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_BLOCK  = 1'b1;

    localparam logic [BLK_W-1:0] FIRST_BLOCK_RESET = 10'd1;
    localparam logic [BLK_W-1:0] LAST_BLOCK_RESET  = 10'd1023;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture an accepted input transaction
        logic commit;  // execute the held item and load the result register
    } bfla_cmd_t;

endpackage

// ===== rtl/core/bfla_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocator request channel
// Valid/ready channel that carries one request transaction.
// ----------------------------------------------------------------------------
interface bfla_in_if;
    logic                          valid;
    logic                          ready;
    logic [bfla_pkg::MODE_W-1:0]   mode;
    logic [bfla_pkg::BLK_W-1:0]    block_number;

    modport source (output valid, output mode, output block_number, input ready);
    modport sink   (input valid, input mode, input block_number, output ready);
endinterface

// ===== rtl/core/bfla_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocator result channel
// Valid/ready channel that carries one result transaction.
// ----------------------------------------------------------------------------
interface bfla_out_if;
    logic                          valid;
    logic                          ready;
    logic [bfla_pkg::BLK_W-1:0]    granted_block;
    logic [bfla_pkg::STAT_W-1:0]   status;
    logic [bfla_pkg::FREE_W-1:0]   free_count;

    modport source (output valid, output granted_block, output status,
                    output free_count, input ready);
    modport sink   (input valid, input granted_block, input status,
                    input free_count, output ready);
endinterface

// ===== rtl/core/bfla_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocator controller
// Sequences accept and execute steps and owns the result valid flag.
// ----------------------------------------------------------------------------
module bfla_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output bfla_pkg::bfla_cmd_t cmd
);
    import bfla_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic slot_free;

    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_valid && in_ready;
    assign cmd.commit = (state_reg == ST_EXEC) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never written over one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // An accepted transaction is always followed by an execute step.
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_EXEC))
        else $error("accept not followed by execute");

    // A new result only appears right after an execute step.
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result valid without execute");

endmodule

// ===== rtl/core/bfla_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block allocator datapath
// Fresh block counter, returned block ring memory, pointers and result.
// ----------------------------------------------------------------------------
module bfla_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  bfla_pkg::bfla_cmd_t                  cmd,
    input  logic                                 cfg_wr_en,
    input  logic [bfla_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bfla_pkg::BLK_W-1:0]           cfg_data,
    input  logic [bfla_pkg::MODE_W-1:0]          in_mode,
    input  logic [bfla_pkg::BLK_W-1:0]           in_block_number,
    output logic [bfla_pkg::BLK_W-1:0]           granted_block,
    output logic [bfla_pkg::STAT_W-1:0]          status,
    output logic [bfla_pkg::FREE_W-1:0]          free_count
);
    import bfla_pkg::*;

    localparam int SUM_W = ((CNT_W > FRESH_W) ? CNT_W : FRESH_W) + 1;

    logic [BLK_W-1:0]   first_block_reg;
    logic [BLK_W-1:0]   last_block_reg;
    logic [FRESH_W-1:0] fresh_next_reg;
    logic [FRESH_W-1:0] fresh_next_next;
    logic [RING_AW-1:0] ring_head_reg;
    logic [RING_AW-1:0] ring_head_next;
    logic [RING_AW-1:0] ring_tail_reg;
    logic [RING_AW-1:0] ring_tail_next;
    logic [CNT_W-1:0]   ring_count_reg;
    logic [CNT_W-1:0]   ring_count_next;

    logic [MODE_W-1:0]  mode_reg;
    logic [BLK_W-1:0]   blk_reg;
    logic [BLK_W-1:0]   rd_data_reg;

    logic [BLK_W-1:0]   granted_reg;
    logic [BLK_W-1:0]   granted_next;
    logic [STAT_W-1:0]  status_reg;
    logic [STAT_W-1:0]  status_next;
    logic [FREE_W-1:0]  free_reg;
    logic [FREE_W-1:0]  free_next;

    logic               ring_wr;
    logic [FRESH_W-1:0] fresh_left_now;
    logic [FRESH_W-1:0] fresh_left_after;
    logic [SUM_W-1:0]   held_now;
    logic [SUM_W-1:0]   held_after;

    logic [BLK_W-1:0]   ring_mem [BLOCK_SLOTS];

    // Fresh blocks left in fresh_next..last_block, zero when the range is spent.
    function automatic logic [FRESH_W-1:0] fresh_left(input logic [FRESH_W-1:0] nxt,
                                                      input logic [BLK_W-1:0]   last);
        logic [FRESH_W-1:0] last_w;
        last_w = FRESH_W'(last);
        if (nxt > last_w)
        begin
            return '0;
        end
        return last_w - nxt + FRESH_W'(1);
    endfunction

    function automatic logic [RING_AW-1:0] ring_advance(input logic [RING_AW-1:0] idx);
        if (idx == RING_AW'(BLOCK_SLOTS - 1))
        begin
            return '0;
        end
        return idx + RING_AW'(1);
    endfunction

    always_comb
    begin
        fresh_left_now  = fresh_left(fresh_next_reg, last_block_reg);
        held_now        = SUM_W'(fresh_left_now) + SUM_W'(ring_count_reg);
        fresh_next_next = fresh_next_reg;
        ring_head_next  = ring_head_reg;
        ring_tail_next  = ring_tail_reg;
        ring_count_next = ring_count_reg;
        granted_next    = '0;
        status_next     = STAT_OK;
        ring_wr         = 1'b0;
        case (mode_reg)
            MODE_ALLOC:
            begin
                if (fresh_left_now != '0)
                begin
                    granted_next    = fresh_next_reg[BLK_W-1:0];
                    fresh_next_next = fresh_next_reg + FRESH_W'(1);
                end
                else if (ring_count_reg != '0)
                begin
                    granted_next    = rd_data_reg;
                    ring_head_next  = ring_advance(ring_head_reg);
                    ring_count_next = ring_count_reg - CNT_W'(1);
                end
                else
                begin
                    status_next = STAT_EMPTY;
                end
            end
            MODE_FREE:
            begin
                if (held_now >= SUM_W'(BLOCK_SLOTS))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    ring_wr         = 1'b1;
                    ring_tail_next  = ring_advance(ring_tail_reg);
                    ring_count_next = ring_count_reg + CNT_W'(1);
                end
            end
            MODE_REBUILD:
            begin
                fresh_next_next = FRESH_W'(first_block_reg);
                ring_head_next  = '0;
                ring_tail_next  = '0;
                ring_count_next = '0;
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
        fresh_left_after = fresh_left(fresh_next_next, last_block_reg);
        held_after       = SUM_W'(fresh_left_after) + SUM_W'(ring_count_next);
        free_next        = held_after[FREE_W-1:0];
    end

    // The ring read port follows the head pointer every cycle; the head does
    // not move between the accept and execute steps.
    always_ff @(posedge clk)
    begin
        rd_data_reg <= ring_mem[ring_head_reg];
        if (cmd.commit && ring_wr)
        begin
            ring_mem[ring_tail_reg] <= blk_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            blk_reg  <= in_block_number;
        end
        if (cmd.commit)
        begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
            free_reg    <= free_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_block_reg <= FIRST_BLOCK_RESET;
            last_block_reg  <= LAST_BLOCK_RESET;
            fresh_next_reg  <= FRESH_W'(FIRST_BLOCK_RESET);
            ring_head_reg   <= '0;
            ring_tail_reg   <= '0;
            ring_count_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FIRST_BLOCK: first_block_reg <= cfg_data;
                    CFG_LAST_BLOCK:  last_block_reg  <= cfg_data;
                    default:         first_block_reg <= first_block_reg;
                endcase
            end
            if (cmd.commit)
            begin
                fresh_next_reg <= fresh_next_next;
                ring_head_reg  <= ring_head_next;
                ring_tail_reg  <= ring_tail_next;
                ring_count_reg <= ring_count_next;
            end
        end
    end

    assign granted_block = granted_reg;
    assign status        = status_reg;
    assign free_count    = free_reg;

    // The ring never holds more entries than it has slots.
    a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= CNT_W'(BLOCK_SLOTS))
        else $error("ring count beyond capacity");

    // An empty ring has its pointers together.
    a_ring_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_count_reg == '0) |-> (ring_head_reg == ring_tail_reg))
        else $error("ring pointers apart while empty");

endmodule

// ===== rtl/core/block_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block free list allocator
// First-in first-out free block list with lazy rebuild and a returned ring.
// ----------------------------------------------------------------------------
// Each request transaction (allocate, free or rebuild) yields exactly one
// result transaction carrying the granted block, a status code and the free
// count after the request. A request is handled in an accept step, in which
// the ring memory read of the head entry is registered, and then an execute
// step that loads the result register. The execute step waits while an
// earlier result is still held, and a new request is accepted only after
// the previous one has executed. A new request may be accepted
// while a finished result waits in the output register. A rebuild is a single
// pointer reset: fresh blocks first_block..last_block are handed out by a
// counter before any returned block, so no memory sweep is needed and the
// ring memory has no clearing pass after reset. The configuration registers
// first_block and last_block may be written only while no request is in
// flight; last_block is used live, first_block only at the next rebuild.
module block_free_list_allocator
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bfla_pkg::BLK_W-1:0]       cfg_data,
    bfla_in_if.sink                          in_ch,
    bfla_out_if.source                       out_ch
);
    import bfla_pkg::*;

    bfla_cmd_t cmd;

    // The controller decides when a transaction is taken and when it runs.
    bfla_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd)
    );

    // The datapath holds all list state and the result payload registers.
    bfla_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_mode         (in_ch.mode),
        .in_block_number (in_ch.block_number),
        .granted_block   (out_ch.granted_block),
        .status          (out_ch.status),
        .free_count      (out_ch.free_count)
    );

endmodule
